@@ hw/rtl/nonuniform_derivative_weights_assert.svh @@
// Assertion macros used by the finite-difference weight block.
`ifndef NONUNIFORM_DERIVATIVE_WEIGHTS_ASSERT_SVH
`define NONUNIFORM_DERIVATIVE_WEIGHTS_ASSERT_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define NDW_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("nonuniform_derivative_weights: check failed");

// Implication with a fixed delay in cycles between antecedent and consequent.
`define NDW_ASSERT_DELAY(label, ante, dly, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##(dly) (cons)) \
      else $error("nonuniform_derivative_weights: delayed check failed");

`endif

@@ hw/rtl/nfdw_pkg.sv @@
// Shared types and constants of the finite-difference weight pipeline.
package nfdw_pkg;

   localparam int OFFSET_W    = 32;
   localparam int WEIGHT_BITS = 48;
   localparam int DIFF_W      = OFFSET_W + 1;
   localparam int SUM_W       = OFFSET_W + 2;
   localparam int PROD_W      = 3 * DIFF_W;
   localparam int LANES       = 4;
   localparam int DIV_STAGES  = WEIGHT_BITS;
   localparam int LANE_LAT    = 5 + DIV_STAGES;
   localparam int TOTAL_LAT   = 3 + LANE_LAT;

   localparam logic [1:0] KIND_D1_TWO   = 2'd0;
   localparam logic [1:0] KIND_D1_THREE = 2'd1;
   localparam logic [1:0] KIND_D2_THREE = 2'd2;
   localparam logic [1:0] KIND_D2_FOUR  = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_CLASH = 2'd1;
   localparam logic [1:0] STATUS_SAT   = 2'd2;

   typedef struct packed {
      logic signed [DIFF_W-1:0] den_a;
      logic signed [DIFF_W-1:0] den_b;
      logic signed [DIFF_W-1:0] den_c;
      logic signed [SUM_W-1:0]  num;
      logic                     neg;
      logic                     wide;
   } lane_op_type;

   typedef struct packed {
      logic [WEIGHT_BITS-1:0] quo;
      logic                   neg;
      logic                   over;
   } lane_res_type;

   typedef struct packed {
      logic             valid;
      logic             clash;
      logic [LANES-1:0] used;
   } item_meta_type;

endpackage

@@ hw/rtl/nfdw_setup.sv @@
// Input register, offset differences and per-weight operand selection.
module nfdw_setup
   import nfdw_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [1:0]                 kind,
   input  logic signed [OFFSET_W-1:0] offset0,
   input  logic signed [OFFSET_W-1:0] offset1,
   input  logic signed [OFFSET_W-1:0] offset2,
   input  logic signed [OFFSET_W-1:0] offset3,
   output lane_op_type                op [LANES],
   output item_meta_type              meta
);

   logic                       valid_ff;
   logic [1:0]                 kind_ff;
   logic signed [OFFSET_W-1:0] x0_ff, x1_ff, x2_ff, x3_ff;
   lane_op_type                op_ff [LANES];
   lane_op_type                op_in [LANES];
   item_meta_type              meta_ff, meta_in;

   logic signed [DIFF_W-1:0] d10, d20, d30, d21, d31, d32;
   logic signed [DIFF_W-1:0] den_one;
   logic signed [SUM_W-1:0]  num_one;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         meta_ff  <= '0;
      end else begin
         valid_ff <= in_valid;
         meta_ff  <= meta_in;
      end
      kind_ff <= kind;
      x0_ff   <= offset0;
      x1_ff   <= offset1;
      x2_ff   <= offset2;
      x3_ff   <= offset3;
      op_ff   <= op_in;
   end

   always_comb begin
      den_one = DIFF_W'(1);
      num_one = SUM_W'(1);
      d10 = DIFF_W'(x1_ff) - DIFF_W'(x0_ff);
      d20 = DIFF_W'(x2_ff) - DIFF_W'(x0_ff);
      d30 = DIFF_W'(x3_ff) - DIFF_W'(x0_ff);
      d21 = DIFF_W'(x2_ff) - DIFF_W'(x1_ff);
      d31 = DIFF_W'(x3_ff) - DIFF_W'(x1_ff);
      d32 = DIFF_W'(x3_ff) - DIFF_W'(x2_ff);
      for (int i = 0; i < LANES; i++) begin
         op_in[i].den_a = den_one;
         op_in[i].den_b = den_one;
         op_in[i].den_c = den_one;
         op_in[i].num   = num_one;
         op_in[i].neg   = 1'b0;
         op_in[i].wide  = 1'b0;
      end
      meta_in.valid = valid_ff;
      case (kind_ff)
         KIND_D1_TWO: begin
            op_in[0].den_a = d10;
            op_in[0].neg   = 1'b1;
            op_in[1].den_a = d10;
            meta_in.used   = 4'b0011;
            meta_in.clash  = (d10 == '0);
         end
         KIND_D1_THREE: begin
            op_in[0].den_a = d10;
            op_in[0].den_b = d20;
            op_in[0].num   = SUM_W'(x2_ff) + SUM_W'(x1_ff);
            op_in[0].neg   = 1'b1;
            op_in[1].den_a = d10;
            op_in[1].den_b = d21;
            op_in[1].num   = SUM_W'(x2_ff) + SUM_W'(x0_ff);
            op_in[2].den_a = d20;
            op_in[2].den_b = d21;
            op_in[2].num   = SUM_W'(x1_ff) + SUM_W'(x0_ff);
            op_in[2].neg   = 1'b1;
            meta_in.used   = 4'b0111;
            meta_in.clash  = (d10 == '0) || (d20 == '0) || (d21 == '0);
         end
         KIND_D2_THREE: begin
            for (int i = 0; i < LANES; i++) op_in[i].wide = 1'b1;
            op_in[0].den_a = d10;
            op_in[0].den_b = d20;
            op_in[1].den_a = d10;
            op_in[1].den_b = d21;
            op_in[1].neg   = 1'b1;
            op_in[2].den_a = d20;
            op_in[2].den_b = d21;
            meta_in.used   = 4'b0111;
            meta_in.clash  = (d10 == '0) || (d20 == '0) || (d21 == '0);
         end
         default: begin
            for (int i = 0; i < LANES; i++) op_in[i].wide = 1'b1;
            op_in[0].den_a = d10;
            op_in[0].den_b = d20;
            op_in[0].den_c = d30;
            op_in[0].num   = SUM_W'(x3_ff) + SUM_W'(x2_ff) + SUM_W'(x1_ff);
            op_in[1].den_a = d10;
            op_in[1].den_b = d21;
            op_in[1].den_c = d31;
            op_in[1].num   = SUM_W'(x3_ff) + SUM_W'(x2_ff) + SUM_W'(x0_ff);
            op_in[1].neg   = 1'b1;
            op_in[2].den_a = d20;
            op_in[2].den_b = d21;
            op_in[2].den_c = d32;
            op_in[2].num   = SUM_W'(x3_ff) + SUM_W'(x1_ff) + SUM_W'(x0_ff);
            op_in[3].den_a = d30;
            op_in[3].den_b = d31;
            op_in[3].den_c = d32;
            op_in[3].num   = SUM_W'(x2_ff) + SUM_W'(x1_ff) + SUM_W'(x0_ff);
            op_in[3].neg   = 1'b1;
            meta_in.used   = 4'b1111;
            meta_in.clash  = (d10 == '0) || (d20 == '0) || (d30 == '0) ||
                             (d21 == '0) || (d31 == '0) || (d32 == '0);
         end
      endcase
   end

   assign op   = op_ff;
   assign meta = meta_ff;

endmodule

@@ hw/rtl/nfdw_lane.sv @@
// One weight lane: magnitudes, denominator product and a pipelined restoring divider.
module nfdw_lane
   import nfdw_pkg::*;
#(
   parameter int OFFSET_FRAC_BITS = 16,
   parameter int WEIGHT_FRAC_BITS = 24
) (
   input  logic         clock,
   input  lane_op_type  op,
   output lane_res_type res
);

   localparam int SHIFT_ONE = OFFSET_FRAC_BITS + WEIGHT_FRAC_BITS;
   localparam int SHIFT_TWO = 2 * OFFSET_FRAC_BITS + WEIGHT_FRAC_BITS + 1;
   localparam int NUM_W     = SUM_W + SHIFT_TWO;
   localparam int REM_W     = PROD_W + WEIGHT_BITS;
   localparam int CMP_W     = (NUM_W > REM_W) ? NUM_W : REM_W;
   localparam int P2_W      = 2 * DIFF_W;

   // Stage 1: magnitudes and overall sign.
   logic [DIFF_W-1:0] ma_in, mb_in, mc_in, ma_ff, mb_ff, mc_ff;
   logic [SUM_W-1:0]  mn_in;
   logic [NUM_W-1:0]  n_in, n1_ff, n2_ff, n3_ff, n4_ff;
   logic              neg_in, neg1_ff, neg2_ff, neg3_ff, neg4_ff;
   // Stages 2 to 4: denominator product, the product of the first two factors split in two halves.
   logic [P2_W-1:0]   p2_ff;
   logic [DIFF_W-1:0] mc2_ff;
   logic [P2_W-1:0]   lo_ff, hi_ff;
   logic [PROD_W-1:0] den_ff;
   // Stage 5 and divider chain.
   logic [REM_W-1:0]       rem_ff [DIV_STAGES+1];
   logic [PROD_W-1:0]      dd_ff  [DIV_STAGES+1];
   logic [WEIGHT_BITS-1:0] quo_ff [DIV_STAGES+1];
   logic                   dneg_ff [DIV_STAGES+1];
   logic                   over_ff [DIV_STAGES+1];

   always_comb begin
      ma_in  = op.den_a[DIFF_W-1] ? DIFF_W'(-op.den_a) : DIFF_W'(op.den_a);
      mb_in  = op.den_b[DIFF_W-1] ? DIFF_W'(-op.den_b) : DIFF_W'(op.den_b);
      mc_in  = op.den_c[DIFF_W-1] ? DIFF_W'(-op.den_c) : DIFF_W'(op.den_c);
      mn_in  = op.num[SUM_W-1] ? SUM_W'(-op.num) : SUM_W'(op.num);
      n_in   = op.wide ? (NUM_W'(mn_in) << SHIFT_TWO) : (NUM_W'(mn_in) << SHIFT_ONE);
      neg_in = op.neg ^ op.num[SUM_W-1] ^ op.den_a[DIFF_W-1] ^ op.den_b[DIFF_W-1] ^
               op.den_c[DIFF_W-1];
   end

   always_ff @(posedge clock) begin
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      mc_ff   <= mc_in;
      n1_ff   <= n_in;
      neg1_ff <= neg_in;

      p2_ff   <= P2_W'(ma_ff) * P2_W'(mb_ff);
      mc2_ff  <= mc_ff;
      n2_ff   <= n1_ff;
      neg2_ff <= neg1_ff;

      lo_ff   <= P2_W'(p2_ff[DIFF_W-1:0]) * P2_W'(mc2_ff);
      hi_ff   <= P2_W'(p2_ff[P2_W-1:DIFF_W]) * P2_W'(mc2_ff);
      n3_ff   <= n2_ff;
      neg3_ff <= neg2_ff;

      den_ff  <= PROD_W'(lo_ff) + (PROD_W'(hi_ff) << DIFF_W);
      n4_ff   <= n3_ff;
      neg4_ff <= neg3_ff;

      over_ff[0] <= CMP_W'(n4_ff) >= (CMP_W'(den_ff) << WEIGHT_BITS);
      rem_ff[0]  <= REM_W'(n4_ff);
      dd_ff[0]   <= den_ff;
      quo_ff[0]  <= '0;
      dneg_ff[0] <= neg4_ff;
   end

   // One quotient bit per stage, most significant first.
   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      localparam int BIT = DIV_STAGES - 1 - s;
      logic [REM_W-1:0]       trial;
      logic                   take;
      logic [REM_W-1:0]       rem_in;
      logic [WEIGHT_BITS-1:0] quo_in;

      always_comb begin
         trial  = REM_W'(dd_ff[s]) << BIT;
         take   = rem_ff[s] >= trial;
         rem_in = take ? (rem_ff[s] - trial) : rem_ff[s];
         quo_in = quo_ff[s];
         quo_in[BIT] = take;
      end

      always_ff @(posedge clock) begin
         rem_ff[s+1]  <= rem_in;
         quo_ff[s+1]  <= quo_in;
         dd_ff[s+1]   <= dd_ff[s];
         dneg_ff[s+1] <= dneg_ff[s];
         over_ff[s+1] <= over_ff[s];
      end
   end

   assign res.quo  = quo_ff[DIV_STAGES];
   assign res.neg  = dneg_ff[DIV_STAGES];
   assign res.over = over_ff[DIV_STAGES];

endmodule

@@ hw/rtl/nonuniform_derivative_weights.sv @@
// Top level of the non-uniform grid finite-difference weight pipeline.
`include "nonuniform_derivative_weights_assert.svh"

// This block turns a derivative mode and up to four grid offsets (signed Q16.16) into
// finite-difference weights (signed Q24.24). A request transfer takes place at every
// rising edge at which start is high; busy is always low, so a new request may follow
// in every cycle. Each request produces exactly one result, shown on the rsp_ ports for
// a single cycle with rsp_strobe high. The receiver cannot stall the result: it must
// take each transfer as it appears. The latency is set by the restoring divider, which
// settles one quotient bit per pipeline stage over the 48 bits of each weight, behind
// two stages of setup, one of operand magnitudes, four of denominator multiplication
// and magnitude compare, and one output stage.
// Coinciding offsets that the mode uses give status STATUS_CLASH and zero weights; a
// clamped weight gives STATUS_SAT. Weights the mode does not use are zero.
module nonuniform_derivative_weights
   import nfdw_pkg::*;
#(
   parameter int OFFSET_FRAC_BITS = 16,
   parameter int WEIGHT_FRAC_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_kind,
   input  logic signed [OFFSET_W-1:0]    req_offset0,
   input  logic signed [OFFSET_W-1:0]    req_offset1,
   input  logic signed [OFFSET_W-1:0]    req_offset2,
   input  logic signed [OFFSET_W-1:0]    req_offset3,
   output logic                          rsp_strobe,
   output logic signed [WEIGHT_BITS-1:0] rsp_weight0,
   output logic signed [WEIGHT_BITS-1:0] rsp_weight1,
   output logic signed [WEIGHT_BITS-1:0] rsp_weight2,
   output logic signed [WEIGHT_BITS-1:0] rsp_weight3,
   output logic [1:0]                    rsp_status
);

   lane_op_type   op [LANES];
   lane_res_type  res [LANES];
   item_meta_type meta_setup;
   // Validity, clash flag and used-lane mask travel alongside the lanes on their own shift line.
   item_meta_type meta_ff [LANE_LAT];

   logic                   valid_out_ff;
   logic [WEIGHT_BITS-1:0] weight_ff [LANES];
   logic [WEIGHT_BITS-1:0] weight_in [LANES];
   logic [1:0]             status_ff, status_in;

   nfdw_setup u_setup (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start),
      .kind     (req_kind),
      .offset0  (req_offset0),
      .offset1  (req_offset1),
      .offset2  (req_offset2),
      .offset3  (req_offset3),
      .op       (op),
      .meta     (meta_setup)
   );

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      nfdw_lane #(
         .OFFSET_FRAC_BITS (OFFSET_FRAC_BITS),
         .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
      ) u_lane (
         .clock (clock),
         .op    (op[i]),
         .res   (res[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LANE_LAT; k++) meta_ff[k] <= '0;
         valid_out_ff <= 1'b0;
      end else begin
         meta_ff[0] <= meta_setup;
         for (int k = 1; k < LANE_LAT; k++) meta_ff[k] <= meta_ff[k-1];
         valid_out_ff <= meta_ff[LANE_LAT-1].valid;
      end
      weight_ff <= weight_in;
      status_ff <= status_in;
   end

   // Saturation limit is 2^47 - 1 for positive weights and 2^47 for negative ones.
   always_comb begin
      logic [WEIGHT_BITS-1:0] limit;
      logic [WEIGHT_BITS-1:0] mag;
      logic                   clamp;
      logic                   sat_any;
      sat_any = 1'b0;
      for (int i = 0; i < LANES; i++) begin
         limit = {1'b0, {(WEIGHT_BITS-1){1'b1}}} + WEIGHT_BITS'(res[i].neg);
         clamp = res[i].over || (res[i].quo > limit);
         mag   = clamp ? limit : res[i].quo;
         if (meta_ff[LANE_LAT-1].used[i] && !meta_ff[LANE_LAT-1].clash) begin
            weight_in[i] = res[i].neg ? (~mag + WEIGHT_BITS'(1)) : mag;
            sat_any      = sat_any | clamp;
         end else begin
            weight_in[i] = '0;
         end
      end
      if (meta_ff[LANE_LAT-1].clash) begin
         status_in = STATUS_CLASH;
      end else if (sat_any) begin
         status_in = STATUS_SAT;
      end else begin
         status_in = STATUS_OK;
      end
   end

   assign busy        = 1'b0;
   assign rsp_strobe  = valid_out_ff;
   assign rsp_weight0 = weight_ff[0];
   assign rsp_weight1 = weight_ff[1];
   assign rsp_weight2 = weight_ff[2];
   assign rsp_weight3 = weight_ff[3];
   assign rsp_status  = status_ff;

   // Every accepted request yields its result on rsp_strobe.
   `NDW_ASSERT_DELAY(a_latency, start, TOTAL_LAT, rsp_strobe)
   // No result appears without a request that fed it.
   `NDW_ASSERT_IMPLY(a_no_spurious, rsp_strobe, $past(start, TOTAL_LAT))
   // Coinciding offsets clear every weight.
   `NDW_ASSERT_IMPLY(a_clash_zero, rsp_strobe && (rsp_status == STATUS_CLASH),
      (rsp_weight0 == '0) && (rsp_weight1 == '0) && (rsp_weight2 == '0) && (rsp_weight3 == '0))

endmodule

@@ tb/sv/nonuniform_derivative_weights_tb.sv @@
// Self-checking testbench for the non-uniform grid finite-difference weight block.
`timescale 1ns / 100ps

module nonuniform_derivative_weights_tb;
   import nfdw_pkg::*;

   localparam int OFF_FRAC  = 16;
   localparam int WGT_FRAC  = 24;
   localparam int N_RANDOM  = 530;
   localparam int N_CALM    = 100;
   localparam int MAX_CYCLE = 200000;

   typedef struct {
      logic [WEIGHT_BITS-1:0] weight [4];
      logic [1:0]             status;
   } weight_set_type;

   // Keeps the weight sets still owed by the block, oldest first, and works out each
   // new set with exact wide arithmetic.
   class weight_scoreboard;
      weight_set_type owed [$];
      int             errors = 0;

      // Signed numerator times 2^shift over the product of the denominators,
      // truncated toward zero and clamped to the 48-bit signed range.
      function automatic logic [WEIGHT_BITS-1:0] ratio(bit neg, longint num, int shift,
            longint den [3], int nd, ref bit sat);
         logic [255:0] n, d, q, limit;
         longint       m;
         if (num < 0) neg = !neg;
         m = (num < 0) ? -num : num;
         n = 256'(m) << shift;
         d = 256'd1;
         for (int i = 0; i < nd; i++) begin
            if (den[i] < 0) neg = !neg;
            m = (den[i] < 0) ? -den[i] : den[i];
            d = d * 256'(m);
         end
         q = n / d;
         limit = (256'd1 << (WEIGHT_BITS - 1)) - (neg ? 256'd0 : 256'd1);
         if (q > limit) begin
            q = limit;
            sat = 1'b1;
         end
         return neg ? WEIGHT_BITS'(-q) : WEIGHT_BITS'(q);
      endfunction

      function void note(logic [1:0] kind, logic signed [31:0] o0, logic signed [31:0] o1,
            logic signed [31:0] o2, logic signed [31:0] o3);
         weight_set_type e;
         longint         x0, x1, x2, x3, d10, d20, d30, d21, d31, d32;
         int             s1, s2;
         bit             clash, sat;
         x0 = o0; x1 = o1; x2 = o2; x3 = o3;
         d10 = x1 - x0; d20 = x2 - x0; d30 = x3 - x0;
         d21 = x2 - x1; d31 = x3 - x1; d32 = x3 - x2;
         s1 = OFF_FRAC + WGT_FRAC;
         s2 = 2 * OFF_FRAC + WGT_FRAC + 1;
         sat = 1'b0;
         foreach (e.weight[i]) e.weight[i] = '0;
         case (kind)
            KIND_D1_TWO: clash = (d10 == 0);
            KIND_D2_FOUR: clash = (d10 == 0 || d20 == 0 || d30 == 0 || d21 == 0 ||
                                   d31 == 0 || d32 == 0);
            default: clash = (d10 == 0 || d20 == 0 || d21 == 0);
         endcase
         if (clash) begin
            e.status = STATUS_CLASH;
         end else begin
            case (kind)
               KIND_D1_TWO: begin
                  e.weight[0] = ratio(1, 1, s1, '{d10, 0, 0}, 1, sat);
                  e.weight[1] = ratio(0, 1, s1, '{d10, 0, 0}, 1, sat);
               end
               KIND_D1_THREE: begin
                  e.weight[0] = ratio(1, x2 + x1, s1, '{d10, d20, 0}, 2, sat);
                  e.weight[1] = ratio(0, x2 + x0, s1, '{d10, d21, 0}, 2, sat);
                  e.weight[2] = ratio(1, x1 + x0, s1, '{d20, d21, 0}, 2, sat);
               end
               KIND_D2_THREE: begin
                  e.weight[0] = ratio(0, 1, s2, '{d10, d20, 0}, 2, sat);
                  e.weight[1] = ratio(1, 1, s2, '{d10, d21, 0}, 2, sat);
                  e.weight[2] = ratio(0, 1, s2, '{d20, d21, 0}, 2, sat);
               end
               default: begin
                  e.weight[0] = ratio(0, x3 + x2 + x1, s2, '{d10, d20, d30}, 3, sat);
                  e.weight[1] = ratio(1, x3 + x2 + x0, s2, '{d10, d21, d31}, 3, sat);
                  e.weight[2] = ratio(0, x3 + x1 + x0, s2, '{d20, d21, d32}, 3, sat);
                  e.weight[3] = ratio(1, x2 + x1 + x0, s2, '{d30, d31, d32}, 3, sat);
               end
            endcase
            e.status = sat ? STATUS_SAT : STATUS_OK;
         end
         owed.push_back(e);
      endfunction

      function void check(weight_set_type got);
         weight_set_type e;
         if (owed.size() == 0) begin
            $error("unexpected result transfer");
            errors++;
            return;
         end
         e = owed.pop_front();
         foreach (e.weight[i])
            if (got.weight[i] !== e.weight[i]) begin
               $error("weight%0d: expected %h, got %h", i, e.weight[i], got.weight[i]);
               errors++;
            end
         if (got.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic [1:0]                    req_kind = KIND_D1_TWO;
   logic signed [OFFSET_W-1:0]    req_offset0 = '0;
   logic signed [OFFSET_W-1:0]    req_offset1 = '0;
   logic signed [OFFSET_W-1:0]    req_offset2 = '0;
   logic signed [OFFSET_W-1:0]    req_offset3 = '0;
   logic                          rsp_strobe;
   logic signed [WEIGHT_BITS-1:0] rsp_weight0, rsp_weight1, rsp_weight2, rsp_weight3;
   logic [1:0]                    rsp_status;

   weight_scoreboard weights_owed = new();
   int               cycle = 0;
   bit               calm = 1'b0;

   always #2 clock = ~clock;

   nonuniform_derivative_weights i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_offset0(req_offset0), .req_offset1(req_offset1),
      .req_offset2(req_offset2), .req_offset3(req_offset3),
      .rsp_strobe(rsp_strobe), .rsp_weight0(rsp_weight0), .rsp_weight1(rsp_weight1),
      .rsp_weight2(rsp_weight2), .rsp_weight3(rsp_weight3), .rsp_status(rsp_status)
   );

   // Every transfer is sampled at the rising edge. A request is noted before the
   // result check of the same edge; the two never belong to each other, since the
   // result of a request only leaves the pipeline at a later edge.
   always @(posedge clock) begin
      weight_set_type got;
      cycle <= cycle + 1;
      if (!reset && start && !busy)
         weights_owed.note(req_kind, req_offset0, req_offset1, req_offset2, req_offset3);
      if (!reset && rsp_strobe) begin
         got.weight = '{rsp_weight0, rsp_weight1, rsp_weight2, rsp_weight3};
         got.status = rsp_status;
         weights_owed.check(got);
      end
      if (cycle >= MAX_CYCLE) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Presents one request from the falling edge and holds it until the block takes
   // the transfer, then sometimes leaves the request line low for a short burst.
   task automatic send_request(logic [1:0] kind, logic [31:0] o0, logic [31:0] o1,
         logic [31:0] o2, logic [31:0] o3);
      @(negedge clock);
      start = 1'b1;
      req_kind = kind;
      req_offset0 = o0; req_offset1 = o1; req_offset2 = o2; req_offset3 = o3;
      do @(posedge clock); while (busy);
      if (!calm && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat ($urandom_range(0, 4)) @(negedge clock);
      end
   endtask

   // Offsets are mostly grid-like: small multiples of a random step with a
   // little jitter. The rest are full-range words, small raw values, or a deliberate
   // coincidence between two points.
   task automatic send_random();
      logic [31:0] o [4];
      int          style, step, src, dst;
      style = $urandom_range(0, 9);
      step  = $urandom_range(6, 20);
      foreach (o[i])
         if (style < 6)
            o[i] = ((int'($urandom_range(0, 16)) - 8) <<< step) + int'($urandom_range(0, 7));
         else if (style < 8)
            o[i] = $urandom;
         else
            o[i] = int'($urandom_range(0, 64)) - 32;
      if ($urandom_range(0, 9) == 0) begin
         src = $urandom_range(0, 3);
         dst = $urandom_range(0, 3);
         o[dst] = o[src];
      end
      send_request(2'($urandom_range(0, 3)), o[0], o[1], o[2], o[3]);
   endtask

   initial begin
      logic [1:0] k;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: a non-uniform grid of whole offsets in every mode, one coincidence per mode,
      // ignored offsets that coincide, unit spacing and the extremes of the range.
      for (int m = 0; m < 4; m++) begin
         k = 2'(m);
         send_request(k, 32'hFFFF_0000, 32'h0001_0000, 32'h0002_0000, 32'hFFFE_0000);
         send_request(k, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
         send_request(k, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'd2);
         send_request(k, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h4000_0000);
         send_request(k, 32'h7FFF_FFFF, 32'h8000_0000, 32'hC000_0000, 32'h0000_0001);
      end
      // The fourth point coinciding with the third only matters in mode 3.
      send_request(KIND_D2_THREE, 32'h1_0000, 32'h2_0000, 32'h3_0000, 32'h3_0000);
      send_request(KIND_D2_FOUR, 32'h1_0000, 32'h2_0000, 32'h3_0000, 32'h3_0000);
      // The third point only matters from mode 1 on.
      send_request(KIND_D1_TWO, 32'h1_0000, 32'h2_0000, 32'h1_0000, 32'h1_0000);

      // Let the pipeline drain completely before the random part.
      @(negedge clock);
      start = 1'b0;
      while (weights_owed.owed.size() != 0) @(posedge clock);

      for (int n = 0; n < N_RANDOM; n++) begin
         calm = (n >= N_RANDOM - N_CALM);
         send_random();
      end

      @(negedge clock);
      start = 1'b0;
      while (weights_owed.owed.size() != 0) @(posedge clock);
      repeat (TOTAL_LAT + 8) @(posedge clock);
      if (weights_owed.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
